// ----- rtl/pfgr_pkg.sv -----
// Package for the proportional glyph renderer: transaction payload types,
// controller states, datapath step codes and status/command structs.
// No dependencies.
`timescale 1ns / 1ps
package pfgr_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_CURSOR = 2'd1,
		OP_DRAW   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_FIXED_WIDTH  = 3'd0,
		CFG_OPAQUE       = 3'd1,
		CFG_ROTATE       = 3'd2,
		CFG_X_SCALE      = 3'd3,
		CFG_Y_SCALE      = 3'd4,
		CFG_CHAR_SPACE   = 3'd5,
		CFG_SCREEN_MAX_X = 3'd6,
		CFG_UNUSED       = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [11:0] font_address;
		logic [7:0]  font_byte;
		logic [7:0]  char_code;
		logic [15:0] new_cursor_x;
		logic [15:0] new_cursor_y;
	} in_item_t;

	typedef struct packed {
		logic [15:0] screen_x;
		logic [15:0] screen_y;
		logic [63:0] ink_mask;
		logic [63:0] write_mask;
		logic [5:0]  advance;
		logic        last;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FS0, ST_FS1, ST_MAXW, ST_HGT, ST_FIRST, ST_CHK, ST_WID,
		ST_DIG, ST_WRAP, ST_SUM, ST_BASE, ST_COL, ST_BIT, ST_EMIT, ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		STEP_NONE, STEP_ACCEPT, STEP_FS0, STEP_FS1, STEP_MAXW, STEP_HGT,
		STEP_FIRST, STEP_CHK, STEP_WID, STEP_DIG, STEP_WRAP, STEP_SUM,
		STEP_BASE, STEP_COL, STEP_BIT, STEP_EMIT, STEP_FIN
	} step_t;

	typedef struct packed {
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic range_bad;
		logic wid_zero;
		logic sum_empty;
		logic sum_last;
		logic cols_none;
		logic col_full;
		logic sx_last;
		logic xc_last;
		logic out_free;
	} sts_t;

	localparam logic [7:0] CODE_NEWLINE = 8'h0a;
	localparam logic [7:0] CODE_ZERO    = 8'h30;
	localparam logic [7:0] CODE_NINE    = 8'h39;
	localparam logic [7:0] THAI_A_LO    = 8'hd4;
	localparam logic [7:0] THAI_A_HI    = 8'hda;
	localparam logic [7:0] THAI_B_LO    = 8'he7;
	localparam logic [7:0] THAI_B_HI    = 8'hec;
	localparam logic [7:0] THAI_MARK    = 8'hd1;
	localparam logic [7:0] WIDTH_TABLE  = 8'd7;

endpackage

// ----- rtl/pfgr_ctrl.sv -----
// Controller FSM of the glyph renderer: sequences header reads, width
// summing, column bit reads and result emission. Uses pfgr_pkg.
`timescale 1ns / 1ps
module pfgr_ctrl
	import pfgr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [1:0] in_op,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd.step = STEP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.step = STEP_ACCEPT;
					if (in_op == OP_DRAW) state_d = ST_FS0;
				end
			end
			ST_FS0:   begin cmd.step = STEP_FS0;   state_d = ST_FS1;   end
			ST_FS1:   begin cmd.step = STEP_FS1;   state_d = ST_MAXW;  end
			ST_MAXW:  begin cmd.step = STEP_MAXW;  state_d = ST_HGT;   end
			ST_HGT:   begin cmd.step = STEP_HGT;   state_d = ST_FIRST; end
			ST_FIRST: begin cmd.step = STEP_FIRST; state_d = ST_CHK;   end
			ST_CHK: begin
				cmd.step = STEP_CHK;
				state_d  = sts.range_bad ? ST_FIN : ST_WID;
			end
			ST_WID: begin
				cmd.step = STEP_WID;
				state_d  = sts.wid_zero ? ST_FIN : ST_DIG;
			end
			ST_DIG: begin cmd.step = STEP_DIG; state_d = ST_WRAP; end
			ST_WRAP: begin
				cmd.step = STEP_WRAP;
				state_d  = sts.sum_empty ? ST_BASE : ST_SUM;
			end
			ST_SUM: begin
				cmd.step = STEP_SUM;
				if (sts.sum_last) state_d = ST_BASE;
			end
			ST_BASE: begin
				cmd.step = STEP_BASE;
				state_d  = sts.cols_none ? ST_FIN : ST_COL;
			end
			ST_COL: begin
				cmd.step = STEP_COL;
				state_d  = sts.col_full ? ST_EMIT : ST_BIT;
			end
			ST_BIT: begin cmd.step = STEP_BIT; state_d = ST_COL; end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.step = STEP_EMIT;
					if (sts.sx_last) state_d = sts.xc_last ? ST_FIN : ST_COL;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.step = STEP_FIN;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_draw_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && in_op == OP_DRAW) |=> state_q == ST_FS0)
		else $error("draw accept did not start header reads");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && sts.out_free) |=> state_q == ST_IDLE)
		else $error("final result did not return to idle");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !sts.out_free) |=> state_q == ST_EMIT)
		else $error("left emit while output stalled");
`endif

endmodule

// ----- rtl/pfgr_datapath.sv -----
// Datapath of the glyph renderer: font memory, config registers, cursor,
// glyph geometry, bit address, column masks and output register. Uses pfgr_pkg.
`timescale 1ns / 1ps
module pfgr_datapath
	import pfgr_pkg::*;
#(
	parameter int FONT_BYTES       = 4096,
	parameter int MAX_GLYPH_WIDTH  = 16,
	parameter int MAX_GLYPH_HEIGHT = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output sts_t      sts,
	input  in_item_t  in_data,
	input  logic      cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int AW = $clog2(FONT_BYTES);
	localparam int PW = AW + 3;

	logic [7:0] mem [FONT_BYTES];
	logic [7:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [16:0] raddr_full;

	logic fixed_q, opaque_q, rotate_q;
	logic [1:0] xs_q;
	logic [2:0] ys_q;
	logic [3:0] cs_q;
	logic [15:0] smax_q;

	logic [15:0] cx_q, cy_q, px_q;
	logic [7:0] fs0_q, fs1_q, maxw_q, hgt_q, first_q, lastc_q, code_q, i_q;
	logic [4:0] cw_q, xc_q, yc_q, hc;
	logic [1:0] sx_q;
	logic skip_q;
	logic [PW-1:0] acc_q, p_q, pcol_q;
	logic [63:0] ink_q, full_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [7:0] ncount, digit_off, rep;
	logic [4:0] cw_rd, cw_max;
	logic [6:0] cwxs, cwxs_rd;
	logic [10:0] hys;
	logic [7:0] idx0;
	logic [127:0] shifted;
	logic is_thai, is_digit, bit_v;
	logic [5:0] adv;

	assign ncount    = code_q - first_q;
	assign digit_off = CODE_ZERO - first_q;
	assign cw_rd     = (rdata_q > 8'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : rdata_q[4:0];
	assign cw_max    = (maxw_q > 8'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : maxw_q[4:0];
	assign hc        = (hgt_q > 8'(MAX_GLYPH_HEIGHT)) ? 5'(MAX_GLYPH_HEIGHT) : hgt_q[4:0];
	assign cwxs      = 7'(cw_q * xs_q);
	assign cwxs_rd   = 7'(cw_rd * xs_q);
	assign hys       = 11'(hgt_q * ys_q);
	assign is_thai   = (code_q >= THAI_A_LO && code_q <= THAI_A_HI) ||
		(code_q >= THAI_B_LO && code_q <= THAI_B_HI) || code_q == THAI_MARK;
	assign is_digit  = code_q >= CODE_ZERO && code_q <= CODE_NINE && first_q <= CODE_ZERO;
	assign idx0      = 8'(yc_q * ys_q);
	assign rep       = 8'((9'd1 << ys_q) - 9'd1);
	assign shifted   = {120'd0, rep} << idx0;
	assign bit_v     = rdata_q[p_q[2:0]];
	assign adv       = skip_q ? 6'd0 : 6'(cwxs + 7'(cs_q));
	assign waddr     = AW'({5'd0, in_data.font_address});

	always_comb begin
		case (cmd.step)
			STEP_FS0:   raddr_full = 17'd1;
			STEP_FS1:   raddr_full = 17'd2;
			STEP_MAXW:  raddr_full = 17'd3;
			STEP_HGT:   raddr_full = 17'd5;
			STEP_FIRST: raddr_full = 17'd6;
			STEP_CHK:   raddr_full = 17'(WIDTH_TABLE) + 17'(ncount);
			STEP_WID:   raddr_full = 17'(WIDTH_TABLE) + 17'(digit_off);
			STEP_WRAP:  raddr_full = 17'(WIDTH_TABLE);
			STEP_SUM:   raddr_full = 17'(WIDTH_TABLE) + 17'(i_q) + 17'd1;
			STEP_COL:   raddr_full = 17'(p_q[PW-1:3]) + 17'd1;
			default:    raddr_full = 17'd0;
		endcase
		raddr = raddr_full[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.step == STEP_ACCEPT && in_data.operation == OP_LOAD)
			mem[waddr] <= in_data.font_byte;
		rdata_q <= mem[raddr];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= 1'b0; opaque_q <= 1'b0; rotate_q <= 1'b0;
			xs_q <= 2'd1; ys_q <= 3'd1; cs_q <= 4'd1; smax_q <= 16'd319;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIXED_WIDTH:  fixed_q  <= cfg_data[0];
				CFG_OPAQUE:       opaque_q <= cfg_data[0];
				CFG_ROTATE:       rotate_q <= cfg_data[0];
				CFG_X_SCALE:      xs_q     <= cfg_data[1:0];
				CFG_Y_SCALE:      ys_q     <= cfg_data[2:0];
				CFG_CHAR_SPACE:   cs_q     <= cfg_data[3:0];
				CFG_SCREEN_MAX_X: smax_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else begin
			case (cmd.step)
				STEP_ACCEPT: if (in_data.operation == OP_CURSOR) begin
					cx_q <= in_data.new_cursor_x;
					cy_q <= in_data.new_cursor_y;
				end
				STEP_CHK: if (code_q == CODE_NEWLINE) begin
					cy_q <= cy_q + 16'(hys);
					cx_q <= '0;
				end
				STEP_WID: if (rdata_q != 8'd0 && !fixed_q && is_thai)
					cx_q <= cx_q - 16'(cwxs_rd);
				STEP_WRAP: if ({1'b0, cx_q} + 17'(cwxs) > {1'b0, smax_q}) begin
					cy_q <= cy_q + 16'(hys);
					cx_q <= '0;
				end
				STEP_FIN: cx_q <= cx_q + 16'(adv);
				default: ;
			endcase
		end
	end

	// glyph geometry and column walk
	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_ACCEPT: begin
				code_q <= in_data.char_code;
				skip_q <= 1'b0;
			end
			STEP_FS0:   fs0_q   <= rdata_q;
			STEP_FS1:   fs1_q   <= rdata_q;
			STEP_MAXW:  maxw_q  <= rdata_q;
			STEP_HGT:   hgt_q   <= rdata_q;
			STEP_FIRST: first_q <= rdata_q;
			STEP_CHK: begin
				lastc_q <= rdata_q;
				skip_q  <= sts.range_bad;
			end
			STEP_WID: begin
				if (rdata_q == 8'd0) skip_q <= 1'b1;
				cw_q <= fixed_q ? cw_max : cw_rd;
			end
			STEP_DIG: if (is_digit) cw_q <= cw_rd;
			STEP_WRAP: begin
				i_q   <= '0;
				acc_q <= '0;
			end
			STEP_SUM: begin
				acc_q <= acc_q + PW'(rdata_q);
				i_q   <= i_q + 8'd1;
			end
			STEP_BASE: begin
				p_q    <= PW'(acc_q * hgt_q) + PW'({9'(lastc_q - first_q) + 9'd7, 3'd0});
				pcol_q <= PW'(acc_q * hgt_q) + PW'({9'(lastc_q - first_q) + 9'd7, 3'd0});
				px_q   <= cx_q;
				xc_q   <= '0;
				yc_q   <= '0;
				sx_q   <= '0;
				ink_q  <= '0;
				full_q <= '0;
			end
			STEP_BIT: begin
				full_q <= full_q | shifted[63:0];
				if (bit_v) ink_q <= ink_q | shifted[63:0];
				yc_q <= yc_q + 5'd1;
				p_q  <= p_q + PW'(1);
			end
			STEP_EMIT: begin
				px_q <= px_q + 16'd1;
				if (sx_q == xs_q - 2'd1) begin
					sx_q   <= '0;
					xc_q   <= xc_q + 5'd1;
					yc_q   <= '0;
					pcol_q <= pcol_q + PW'(hgt_q);
					p_q    <= pcol_q + PW'(hgt_q);
					ink_q  <= '0;
					full_q <= '0;
				end else begin
					sx_q <= sx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.step == STEP_EMIT || cmd.step == STEP_FIN) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.step == STEP_EMIT) begin
			out_q.screen_x   <= rotate_q ? cy_q : px_q;
			out_q.screen_y   <= rotate_q ? px_q : cy_q;
			out_q.ink_mask   <= ink_q;
			out_q.write_mask <= opaque_q ? full_q : ink_q;
			out_q.advance    <= '0;
			out_q.last       <= 1'b0;
		end else if (cmd.step == STEP_FIN) begin
			out_q.screen_x   <= '0;
			out_q.screen_y   <= '0;
			out_q.ink_mask   <= '0;
			out_q.write_mask <= '0;
			out_q.advance    <= adv;
			out_q.last       <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.range_bad = code_q < first_q || code_q > rdata_q || {fs1_q, fs0_q} == 16'd0;
		sts.wid_zero  = rdata_q == 8'd0;
		sts.sum_empty = ncount == 8'd0;
		sts.sum_last  = {1'b0, i_q} + 9'd1 == {1'b0, ncount};
		sts.cols_none = cw_q == 5'd0 || xs_q == 2'd0;
		sts.col_full  = yc_q == hc;
		sts.sx_last   = sx_q == xs_q - 2'd1;
		sts.xc_last   = xc_q == cw_q - 5'd1;
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/proportional_font_glyph_renderer.sv -----
// Top level of the proportional font glyph renderer: joins the controller
// FSM and the datapath. Depends on pfgr_pkg, pfgr_ctrl, pfgr_datapath.
`timescale 1ns / 1ps
// Usage:
//  in channel (in_valid/in_ready/in_data): one transaction per operation.
//   Load writes one font byte, set cursor loads the text cursor; neither
//   gives a result. Operation 3 is dropped.
//  Draw: reads the font header, checks the code, reads the glyph width and
//   digit width, then sums earlier glyph widths at one font byte per cycle,
//   forms the bit address, and walks the glyph: per column it reads each
//   pixel bit (at most MAX_GLYPH_HEIGHT bits; one font memory read port),
//   then sends x_scale column transactions, one per cycle while the
//   receiver keeps out_ready high. A final transaction with last=1
//   carries the advance. The single memory read port and any receiver
//   stalls set the rate.
//  in_ready is high only while idle; one item is processed at a time.
//  out channel: a result register; when out_ready is low the controller
//   waits with the result held and resumes when it is taken.
//  cfg channel: always ready, writes one register per transaction; write
//   only while idle.
//  Reset: config registers take their defaults, cursor goes to 0, no output
//   pending. Font memory is not cleared: load it before drawing.
module proportional_font_glyph_renderer
	import pfgr_pkg::*;
#(
	parameter int FONT_BYTES       = 4096,
	parameter int MAX_GLYPH_WIDTH  = 16,
	parameter int MAX_GLYPH_HEIGHT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// configuration writes land the same cycle
	assign cfg_ready = 1'b1;

	pfgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfgr_datapath #(
		.FONT_BYTES       (FONT_BYTES),
		.MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- dv/tb_proportional_font_glyph_renderer.sv -----
// Self-checking testbench for proportional_font_glyph_renderer: random and
// directed font loads, cursor moves and character draws, checked against an
// in-bench glyph predictor. Depends on pfgr_pkg and the renderer RTL.
`timescale 1ns / 1ps
module tb_proportional_font_glyph_renderer;
	import pfgr_pkg::*;

	localparam int MEM_BYTES   = 4096;
	localparam int MAX_W       = 16;
	localparam int MAX_H       = 16;
	// font bytes written up front; every draw stays inside written bytes
	localparam int FILL_BYTES  = 160;
	// watchdog bound on clocks with no handshake at all
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 50;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	proportional_font_glyph_renderer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------
	// Predictor state: shadow font image, cursor and registers
	// ---------------------------------------------------------------
	logic [7:0]  font_img [MEM_BYTES];
	int unsigned cur_x, cur_y;
	int unsigned r_fixed, r_opaque, r_rotate, r_xs, r_ys, r_space, r_maxx;

	in_item_t  op_queue[$];      // operations waiting for the driver
	out_item_t column_queue[$];  // expected column / final transactions

	int in_idle_pct, out_idle_pct;
	int mismatches;
	int stall_cycles;

	// stimulus-side knowledge of the font currently being built
	int unsigned gen_first, gen_last;
	logic [7:0]  gen_img [MEM_BYTES];
	bit          gen_wr  [MEM_BYTES];

	function automatic int unsigned font_rd(int unsigned addr);
		return font_img[addr % MEM_BYTES];
	endfunction

	function automatic int unsigned clamp_width(int unsigned w);
		return (w > MAX_W) ? MAX_W : w;
	endfunction

	function automatic void push_col(int unsigned sx, int unsigned sy, logic [63:0] ink,
			logic [63:0] wr, int unsigned adv, logic fin);
		out_item_t r;
		r.screen_x   = sx[15:0];
		r.screen_y   = sy[15:0];
		r.ink_mask   = ink;
		r.write_mask = wr;
		r.advance    = adv[5:0];
		r.last       = fin;
		column_queue.push_back(r);
	endfunction

	// Works out every column transaction for one drawn character.
	function automatic void predict_glyph(int unsigned c);
		int unsigned fsize, maxw, hgt, first, lastc, cw, hc, base, p, pbit, idx, px, adv;
		logic [63:0] ink, full;
		fsize = font_rd(0) | (font_rd(1) << 8);
		maxw  = font_rd(2);
		hgt   = font_rd(3);
		first = font_rd(5);
		lastc = font_rd(6);
		if (c == CODE_NEWLINE) begin
			cur_y = (cur_y + hgt * r_ys) & 16'hffff;
			cur_x = 0;
		end
		if (c < first || c > lastc || fsize == 0) begin
			push_col(0, 0, '0, '0, 0, 1'b1);
			return;
		end
		cw = font_rd(WIDTH_TABLE + c - first);
		if (cw == 0) begin
			push_col(0, 0, '0, '0, 0, 1'b1);
			return;
		end
		cw = clamp_width(cw);
		if (r_fixed != 0) begin
			cw = clamp_width(maxw);
		end else if ((c >= THAI_A_LO && c <= THAI_A_HI) ||
				(c >= THAI_B_LO && c <= THAI_B_HI) || c == THAI_MARK) begin
			// combining mark: step back by its own scaled width
			cur_x = (cur_x - cw * r_xs) & 16'hffff;
		end
		if (c >= CODE_ZERO && c <= CODE_NINE && first <= CODE_ZERO)
			cw = clamp_width(font_rd(WIDTH_TABLE + CODE_ZERO - first));
		if (cur_x + cw * r_xs > r_maxx) begin
			cur_y = (cur_y + hgt * r_ys) & 16'hffff;
			cur_x = 0;
		end
		// bit offset of the glyph: sum of all earlier widths times height, from just past the width table
		base = 0;
		for (int unsigned i = 0; i < c - first; i++)
			base += font_rd(WIDTH_TABLE + i);
		base = base * hgt + (lastc - first + WIDTH_TABLE) * 8;
		hc = (hgt > MAX_H) ? MAX_H : hgt;
		for (int unsigned xc = 0; xc < cw; xc++) begin
			ink  = '0;
			full = '0;
			for (int unsigned yc = 0; yc < hc; yc++) begin
				p    = base + xc * hgt + yc;
				pbit = (font_rd((p >> 3) + 1) >> (p & 7)) & 1;
				for (int unsigned sy = 0; sy < r_ys; sy++) begin
					idx = yc * r_ys + sy;
					if (idx < 64) begin
						full[idx] = 1'b1;
						if (pbit != 0)
							ink[idx] = 1'b1;
					end
				end
			end
			for (int unsigned sx = 0; sx < r_xs; sx++) begin
				px = (cur_x + xc * r_xs + sx) & 16'hffff;
				if (r_rotate != 0)
					push_col(cur_y, px, ink, (r_opaque != 0) ? full : ink, 0, 1'b0);
				else
					push_col(px, cur_y, ink, (r_opaque != 0) ? full : ink, 0, 1'b0);
			end
		end
		adv   = cw * r_xs + r_space;
		cur_x = (cur_x + adv) & 16'hffff;
		push_col(0, 0, '0, '0, adv, 1'b1);
	endfunction

	function automatic void apply_op(in_item_t it);
		case (op_t'(it.operation))
			OP_LOAD:   font_img[it.font_address] = it.font_byte;
			OP_CURSOR: begin
				cur_x = 32'(it.new_cursor_x);
				cur_y = 32'(it.new_cursor_y);
			end
			OP_DRAW:   predict_glyph(32'(it.char_code));
			default:   ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Clock and reset
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Driver: takes operations from op_queue, random gaps on valid
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready)
				apply_op(in_data);
			if (!in_valid || in_ready) begin
				if (op_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= op_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random back-pressure, compare against oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready    <= 1'b0;
			stall_cycles <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
			if (out_valid && out_ready) begin
				if (column_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: %p", out_data);
				end else begin
					want = column_queue.pop_front();
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
			// watchdog: any handshake counts as progress
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles > STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// register writes seen by the block update the shadow registers
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIXED_WIDTH:  r_fixed  = 32'(cfg_data[0]);
				CFG_OPAQUE:       r_opaque = 32'(cfg_data[0]);
				CFG_ROTATE:       r_rotate = 32'(cfg_data[0]);
				CFG_X_SCALE:      r_xs     = 32'(cfg_data[1:0]);
				CFG_Y_SCALE:      r_ys     = 32'(cfg_data[2:0]);
				CFG_CHAR_SPACE:   r_space  = 32'(cfg_data[3:0]);
				CFG_SCREEN_MAX_X: r_maxx   = 32'(cfg_data);
				default:          ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic in_item_t noise_item(op_t op);
		in_item_t it;
		it.operation    = op;
		it.font_address = 12'($urandom);
		it.font_byte    = 8'($urandom);
		it.char_code    = 8'($urandom);
		it.new_cursor_x = 16'($urandom);
		it.new_cursor_y = 16'($urandom);
		return it;
	endfunction

	function automatic bit gen_ok(int unsigned addr);
		return gen_wr[addr % MEM_BYTES];
	endfunction

	function automatic int unsigned gen_rd(int unsigned addr);
		return 32'(gen_img[addr % MEM_BYTES]);
	endfunction

	// 1 when every font byte a draw of c reads has been loaded before it
	function automatic bit draw_safe(int unsigned c);
		int unsigned fsize, maxw, hgt, first, lastc, cw, hc, base, p;
		if (!gen_ok(0) || !gen_ok(1) || !gen_ok(2) || !gen_ok(3) ||
				!gen_ok(5) || !gen_ok(6))
			return 1'b0;
		fsize = gen_rd(0) | (gen_rd(1) << 8);
		maxw  = gen_rd(2);
		hgt   = gen_rd(3);
		first = gen_rd(5);
		lastc = gen_rd(6);
		if (c < first || c > lastc || fsize == 0)
			return 1'b1;
		if (!gen_ok(WIDTH_TABLE + c - first))
			return 1'b0;
		cw = gen_rd(WIDTH_TABLE + c - first);
		if (cw == 0)
			return 1'b1;
		cw = clamp_width(cw);
		if (r_fixed != 0)
			cw = clamp_width(maxw);
		if (c >= CODE_ZERO && c <= CODE_NINE && first <= CODE_ZERO) begin
			if (!gen_ok(WIDTH_TABLE + CODE_ZERO - first))
				return 1'b0;
			cw = clamp_width(gen_rd(WIDTH_TABLE + CODE_ZERO - first));
		end
		base = 0;
		for (int unsigned i = 0; i < c - first; i++) begin
			if (!gen_ok(WIDTH_TABLE + i))
				return 1'b0;
			base += gen_rd(WIDTH_TABLE + i);
		end
		base = base * hgt + (lastc - first + WIDTH_TABLE) * 8;
		hc = (hgt > MAX_H) ? MAX_H : hgt;
		for (int unsigned xc = 0; xc < cw; xc++)
			for (int unsigned yc = 0; yc < hc; yc++) begin
				p = base + xc * hgt + yc;
				if (!gen_ok((p >> 3) + 1))
					return 1'b0;
			end
		return 1'b1;
	endfunction

	task automatic q_load(int unsigned addr, int unsigned data);
		in_item_t it;
		it = noise_item(OP_LOAD);
		it.font_address = addr[11:0];
		it.font_byte    = data[7:0];
		gen_img[addr[11:0]] = data[7:0];
		gen_wr[addr[11:0]]  = 1'b1;
		op_queue.push_back(it);
	endtask

	task automatic q_cursor(int unsigned x, int unsigned y);
		in_item_t it;
		it = noise_item(OP_CURSOR);
		it.new_cursor_x = x[15:0];
		it.new_cursor_y = y[15:0];
		op_queue.push_back(it);
	endtask

	// a draw that would touch unloaded font bytes becomes a cursor move
	task automatic q_draw(int unsigned c);
		in_item_t it;
		if (draw_safe(c & 8'hff)) begin
			it = noise_item(OP_DRAW);
			it.char_code = c[7:0];
			op_queue.push_back(it);
		end else begin
			q_cursor($urandom, $urandom);
		end
	endtask

	// width table entries: mostly legal, some zero, some over the clamp
	function automatic int unsigned rand_width();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return 0;
		if (r < 16)
			return $urandom_range(MAX_W + 1, 20);
		return $urandom_range(1, 8);
	endfunction

	// Header and width table. Glyph bits come from the initial fill.
	task automatic q_font(int unsigned maxw, int unsigned hgt, int unsigned first,
			int unsigned lastc);
		q_load(0, $urandom_range(1, 255));
		q_load(1, $urandom_range(0, 15));
		q_load(2, maxw);
		q_load(3, hgt);
		q_load(4, $urandom);
		q_load(5, first);
		q_load(6, lastc);
		for (int unsigned i = 0; i <= lastc - first; i++)
			q_load(WIDTH_TABLE + i, rand_width());
		gen_first = first;
		gen_last  = lastc;
	endtask

	// small fonts of a few codes: digits, combining marks, newline or any
	task automatic q_font_random();
		int unsigned kind, hgt, first, lastc;
		kind = $urandom_range(3);
		hgt  = ($urandom_range(3) == 0) ? $urandom_range(MAX_H + 1, 20) :
			$urandom_range(1, 12);
		case (kind)
			0: begin
				first = $urandom_range(8'h2c, CODE_ZERO);
				lastc = CODE_NINE;
			end
			1: begin
				first = $urandom_range(1) ? THAI_MARK : 32'(THAI_B_LO) - 1;
				lastc = (first == THAI_MARK) ? 32'(THAI_A_LO) + 2 : 32'(THAI_B_HI);
			end
			2: begin
				first = CODE_NEWLINE;
				lastc = CODE_NEWLINE + $urandom_range(2, 7);
			end
			default: begin
				first = $urandom_range(8'h20, 8'hf0);
				lastc = first + $urandom_range(1, 7);
			end
		endcase
		q_font($urandom_range(0, 20), hgt, first, lastc);
	endtask

	// Lets every queued operation go out and every expected result return.
	task automatic drain();
		while (op_queue.size() != 0 || in_valid || column_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(cfg_idx_t idx, int unsigned data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[15:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic reg_all(int unsigned fw, int unsigned op, int unsigned rot,
			int unsigned xs, int unsigned ys, int unsigned sp, int unsigned mx);
		reg_write(CFG_FIXED_WIDTH, fw);
		reg_write(CFG_OPAQUE, op);
		reg_write(CFG_ROTATE, rot);
		reg_write(CFG_X_SCALE, xs);
		reg_write(CFG_Y_SCALE, ys);
		reg_write(CFG_CHAR_SPACE, sp);
		reg_write(CFG_SCREEN_MAX_X, mx);
	endtask

	task automatic q_random_op();
		int unsigned r, k;
		in_item_t it;
		r = $urandom_range(99);
		if (r < 70) begin
			k = $urandom_range(99);
			if (k < 60)
				q_draw($urandom_range(gen_first, gen_last));
			else if (k < 70)
				q_draw(CODE_ZERO + $urandom_range(0, 9));
			else if (k < 82)
				q_draw($urandom_range(0, 1) ? THAI_A_LO + $urandom_range(0, 6) :
					THAI_B_LO + $urandom_range(0, 5));
			else if (k < 87)
				q_draw(CODE_NEWLINE);
			else
				q_draw($urandom_range(0, 255));
		end else if (r < 85) begin
			// near the wrap edge half the time
			if ($urandom_range(1))
				q_cursor((r_maxx - $urandom_range(0, 40)) & 16'hffff, $urandom);
			else
				q_cursor($urandom, $urandom);
		end else if (r < 97) begin
			// reshape widths and glyph bits, never the header
			q_load($urandom_range(WIDTH_TABLE, FILL_BYTES - 1), $urandom);
		end else begin
			it = noise_item(OP_NONE);
			op_queue.push_back(it);
		end
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_idle_pct = 29;
		out_idle_pct = 57;
		mismatches  = 0;
		cur_x = 0;
		cur_y = 0;
		r_fixed = 0; r_opaque = 0; r_rotate = 0;
		r_xs = 1; r_ys = 1; r_space = 1; r_maxx = 319;
		gen_first = 0;
		gen_last  = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// header, width tables and glyph bits all live in this region
		for (int unsigned a = 0; a < FILL_BYTES; a++)
			q_load(a, $urandom);
		drain();

		// directed: default registers, newline font with odd widths
		q_font(20, MAX_H, CODE_NEWLINE, CODE_NEWLINE + 3);
		q_load(WIDTH_TABLE + 0, 3);
		q_load(WIDTH_TABLE + 1, 0);                         // zero-width glyph
		q_load(WIDTH_TABLE + 2, 20);                        // over-wide glyph
		q_load(WIDTH_TABLE + 3, 4);
		q_draw(CODE_NEWLINE);
		q_draw(CODE_NEWLINE + 1);
		q_draw(CODE_NEWLINE + 2);
		q_draw(CODE_NEWLINE + 3);
		q_cursor(316, 0);                                   // wraps to the next line
		q_draw(CODE_NEWLINE + 3);
		q_draw(8'h00);                                      // below first code
		q_draw(8'hff);                                      // above last code
		op_queue.push_back(noise_item(OP_NONE));
		drain();
		// digits with uniform width
		q_font(6, 10, CODE_ZERO, CODE_NINE);
		q_draw(CODE_ZERO);
		q_draw(CODE_NINE);
		q_draw(CODE_ZERO + 5);
		drain();
		// combining marks
		q_font(8, 8, THAI_MARK, THAI_A_LO + 2);
		q_load(WIDTH_TABLE + 0, 5);
		q_draw(THAI_MARK);
		q_cursor(0, 16'hffff);                              // mark steps back below 0
		q_draw(THAI_A_LO);
		q_draw(THAI_A_LO + 2);
		drain();
		// empty font, tall font, digits with first code above zero
		q_load(0, 0);
		q_load(1, 0);
		q_draw(8'h50);
		drain();
		q_font(6, 20, 8'h31, 8'h3a);
		q_draw(CODE_ZERO);
		q_draw(8'h35);
		q_draw(CODE_NINE);
		q_draw(8'h3a);
		drain();

		// random phases: three idling modes, two register settings each
		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct  = (ph == 0) ? 29 : (ph == 1) ? 57 : 0;
			out_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 29 : 0;
			for (int s = 0; s < 2; s++) begin
				if (ph == 0 && s == 0)
					reg_all(0, 0, 0, 1, 1, 0, 0);
				else if (ph == 2 && s == 1)
					reg_all(1, 1, 1, 3, 4, 15, 16'hffff);
				else
					reg_all($urandom_range(1), $urandom_range(1), $urandom_range(1),
						$urandom_range(1, 3), $urandom_range(1, 4),
						$urandom_range(0, 15), $urandom_range(0, 16'hffff));
				q_font_random();
				for (int n = 0; n < 24; n++)
					q_random_op();
				drain();
			end
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/pfgr_pkg.sv
rtl/pfgr_ctrl.sv
rtl/pfgr_datapath.sv
rtl/proportional_font_glyph_renderer.sv
dv/tb_proportional_font_glyph_renderer.sv
